>>> rtl/rlhrm_pkg.sv
// Package for the red LED hue redness map: widths, reset values and the
// request word of the shared serial divider.
// No dependencies; used by rlhrm_div and the top-level unit.
`default_nettype none

package rlhrm_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned LwW      = 12;
  localparam int unsigned PixW     = 8;
  localparam int unsigned WordW    = 2 * PixW;

  localparam int unsigned DivNumW  = 18;
  localparam int unsigned DivDenW  = 10;
  localparam int unsigned DivQuotW = 9;
  localparam int unsigned DivCntW  = $clog2(DivQuotW + 1);

  localparam logic [LwW-1:0]     LineWidthReset  = 12'd640;
  localparam logic [PixW-1:0]    GrayNoNeighbour = 8'd128;
  localparam logic [PixW-1:0]    PixMax          = 8'd255;
  localparam logic [DivDenW-1:0] GrayThreeDiv    = 10'd6;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> rtl/rlhrm_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on rlhrm_pkg for widths and the request word.
`default_nettype none

module rlhrm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlhrm_pkg::div_req_t               req_i,
  output logic                              done_o,
  output logic [rlhrm_pkg::DivQuotW-1:0]    quot_o
);

  logic [rlhrm_pkg::DivNumW-1:0]  rem_q;
  logic [rlhrm_pkg::DivNumW-1:0]  dsh_q;
  logic [rlhrm_pkg::DivQuotW-1:0] quot_q;
  logic [rlhrm_pkg::DivCntW-1:0]  cnt_q;
  logic                           done_q;
  logic                           fits;

  assign fits   = (rem_q >= dsh_q);
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= rlhrm_pkg::DivCntW'(rlhrm_pkg::DivQuotW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rlhrm_pkg::DivCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      dsh_q  <= rlhrm_pkg::DivNumW'(req_i.divisor) << (rlhrm_pkg::DivQuotW - 1);
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[rlhrm_pkg::DivQuotW-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/red_led_hue_redness_map_unit.sv
// Red LED redness map: one 8-bit redness word per B,G,R pixel word.
// Depends on rlhrm_pkg and rlhrm_div.
//
// Pixel words enter on the s_axis channel in raster order, with the frame
// start flag on tuser; one redness word leaves on the m_axis channel for
// every pixel. The row width is written through cfg_we_i and cfg_wdata_i, only
// while the block is idle; the user is bound to this, the block does not enforce it.
// Each pixel is handled alone: s_axis_tready is high only between pixels.
// A coloured pixel passes through the prep, divide and finish states before the
// next possible acceptance, the divide state taking the nine steps of the serial
// divider; a gray pixel with both left and upper neighbours and a positive sum
// does the same, other gray pixels skip the divide state.
// The result enters the output register as the block returns to idle.
// The output register lets the next pixel be accepted while a result waits;
// if the receiver still stalls when the next result is ready, the block
// holds that result and stays busy until the register is free.
// Reset clears the row counter and the left and upper-left neighbour registers, sets the width
// to 640 and treats the next pixel as the start of a frame. The row store
// needs no clearing.
`default_nettype none

module red_led_hue_redness_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue, green, red
  input  logic [0:0]  s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // redness
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);

  typedef enum logic [1:0] {StIdle, StPrep, StDiv, StFin} state_e;

  localparam int unsigned PixW  = rlhrm_pkg::PixW;
  localparam int unsigned ColW  = rlhrm_pkg::ColW;
  localparam int unsigned WordW = rlhrm_pkg::WordW;

  function automatic logic [PixW-1:0] sat_byte(input logic [11:0] v);
    logic [PixW-1:0] r;
    r = (v > 12'(rlhrm_pkg::PixMax)) ? rlhrm_pkg::PixMax : v[PixW-1:0];
    return r;
  endfunction

  function automatic logic signed [10:0] recovered(input logic [WordW-1:0] p);
    logic signed [10:0] r;
    r = $signed({2'b00, p[WordW-1:PixW], 1'b0}) - $signed({3'b000, p[PixW-1:0]});
    return r;
  endfunction

  state_e                  state_q;
  logic [rlhrm_pkg::LwW-1:0] lw_q;
  logic [ColW-1:0]         col_cnt_q;
  logic                    first_row_q;
  logic [WordW-1:0]        left_q;
  logic [WordW-1:0]        upleft_q;
  logic [PixW-1:0]         blue_q;
  logic [PixW-1:0]         green_q;
  logic [PixW-1:0]         red_q;
  logic [ColW-1:0]         col_q;
  logic                    fr_q;
  logic [WordW-1:0]        upper_q;
  logic [PixW-1:0]         res_q;
  logic                    colour_q;
  logic                    out_valid_q;
  logic [PixW-1:0]         out_data_q;
  logic [WordW-1:0]        row_mem [rlhrm_pkg::MaxWidth];

  logic [rlhrm_pkg::LwW-1:0] width_act;
  logic                    accept;
  logic [ColW-1:0]         col_d;
  logic                    fr_d;
  logic                    can_load;
  logic                    mem_we;
  logic [WordW-1:0]        word;
  logic [31:0]             col_next;

  logic [PixW-1:0]         mx;
  logic [PixW-1:0]         mn;
  logic [PixW-1:0]         dlt;
  logic [9:0]              d3;
  logic [10:0]             n;
  logic [9:0]              diffn;
  logic [rlhrm_pkg::DivNumW-1:0] num;
  logic                    is_colour;
  logic                    has_left;
  logic                    has_up;
  logic signed [11:0]      term_l;
  logic signed [11:0]      term_u;
  logic signed [11:0]      term_ul;
  logic signed [12:0]      t;
  logic                    t_pos;
  logic [8:0]              gray_none;
  logic [9:0]              colour_sum;

  rlhrm_pkg::div_req_t            div_req;
  logic                           div_done;
  logic [rlhrm_pkg::DivQuotW-1:0] div_quot;

  always_comb begin
    width_act = lw_q;
    if (lw_q == '0) begin
      width_act = rlhrm_pkg::LwW'(1);
    end else if (32'(lw_q) > rlhrm_pkg::MaxWidth) begin
      width_act = rlhrm_pkg::LwW'(rlhrm_pkg::MaxWidth);
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_cnt_q;
    fr_d  = first_row_q;
    if (s_axis_tuser[0]) begin
      col_d = '0;
      fr_d  = 1'b1;
    end else if (32'(col_cnt_q) >= 32'(width_act)) begin
      col_d = '0;
      fr_d  = 1'b0;
    end
  end

  // Colour path: hue distance from red and the scaled numerator.
  always_comb begin
    mx = (blue_q > green_q) ? blue_q : green_q;
    if (red_q > mx) begin
      mx = red_q;
    end
    mn = (blue_q < green_q) ? blue_q : green_q;
    if (red_q < mn) begin
      mn = red_q;
    end
    dlt = mx - mn;
    d3  = {1'b0, dlt, 1'b0} + 10'(dlt);
    if (red_q == mx) begin
      n = (green_q >= blue_q) ? 11'(green_q - blue_q) : 11'(blue_q - green_q);
    end else if (green_q == mx) begin
      n = 11'({dlt, 1'b0}) + 11'(blue_q) - 11'(red_q);
    end else begin
      n = 11'({dlt, 1'b0}) + 11'(green_q) - 11'(red_q);
    end
    diffn     = d3 - n[9:0];
    num       = {diffn, 8'b0} - rlhrm_pkg::DivNumW'(diffn);
    is_colour = (mx != mn);
  end

  // Gray path: neighbour scores recovered from stored output and red.
  always_comb begin
    has_left  = (col_q != '0);
    has_up    = !fr_q;
    term_l    = $signed({4'b0000, red_q}) + 12'(recovered(left_q));
    term_u    = $signed({4'b0000, red_q}) + 12'(recovered(upper_q));
    term_ul   = $signed({4'b0000, red_q}) + 12'(recovered(upleft_q));
    t = '0;
    if (has_left) begin
      t = t + 13'(term_l);
    end
    if (has_up) begin
      t = t + 13'(term_u);
    end
    if (has_left && has_up) begin
      t = t + 13'(term_ul);
    end
    t_pos     = !t[12] && (t != '0);
    gray_none = 9'(red_q) + 9'(rlhrm_pkg::GrayNoNeighbour);
  end

  always_comb begin
    div_req.start    = (state_q == StPrep) &&
                       (is_colour || (has_left && has_up && t_pos));
    div_req.dividend = is_colour ? num : rlhrm_pkg::DivNumW'(t[11:0]);
    div_req.divisor  = is_colour ? d3 : rlhrm_pkg::GrayThreeDiv;
  end

  rlhrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign colour_sum = 10'(red_q) + 10'(div_quot);
  assign can_load   = !out_valid_q || m_axis_tready;
  assign mem_we     = (state_q == StFin) && can_load;
  assign word       = {res_q, red_q};
  assign col_next   = 32'(col_q) + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lw_q        <= rlhrm_pkg::LineWidthReset;
      col_cnt_q   <= '0;
      first_row_q <= 1'b1;
      left_q      <= '0;
      upleft_q    <= '0;
      res_q       <= '0;
      colour_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        lw_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready && !mem_we) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          colour_q <= is_colour;
          if (div_req.start) begin
            state_q <= StDiv;
          end else begin
            state_q <= StFin;
            if (!has_left && !has_up) begin
              res_q <= gray_none[8:1];
            end else if (!t_pos) begin
              res_q <= '0;
            end else begin
              res_q <= sat_byte(12'(t[12:1]));
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StFin;
            res_q   <= colour_q ? colour_sum[8:1] : sat_byte(12'(div_quot));
          end
        end
        StFin: begin
          if (can_load) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            upleft_q    <= upper_q;
            left_q      <= word;
            if (col_next >= 32'(width_act)) begin
              col_cnt_q   <= '0;
              first_row_q <= 1'b0;
            end else begin
              col_cnt_q   <= col_next[ColW-1:0];
              first_row_q <= fr_q;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blue_q  <= s_axis_tdata[7:0];
      green_q <= s_axis_tdata[15:8];
      red_q   <= s_axis_tdata[23:16];
      col_q   <= col_d;
      fr_q    <= fr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[col_q] <= word;
    end
    if (accept) begin
      upper_q <= row_mem[col_d];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/rlhrm_checker.sv
// Port-level checks for the red LED hue redness map, bound to the top level.
// Depends only on the ports of red_led_hue_redness_map_unit.
`default_nettype none

module rlhrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled output word must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Only one pixel is in work at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("pixel accepted while the previous one is in work");

  // A result cannot appear in the cycle after its pixel was accepted.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid))
    else $error("result word appeared too early");

endmodule

bind red_led_hue_redness_map_unit rlhrm_checker u_rlhrm_checker (.*);

`default_nettype wire

>>> tb/tb_red_led_hue_redness_map_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for red_led_hue_redness_map_unit: directed and random B,G,R pixel
// words over several row widths, each redness word compared with an in-line predictor.
// Depends on rlhrm_pkg and the RTL of the unit; reads no files.

module tb_red_led_hue_redness_map_unit;
  import rlhrm_pkg::*;

  localparam int unsigned RandomPixels = 1150;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned WidthSettle  = 4;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned ReportMax    = 10;

  typedef enum logic {ENT_PIXEL, ENT_WIDTH} entry_kind_e;

  typedef struct {
    entry_kind_e     kind;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
    logic            frame_start;
    logic [LwW-1:0]  width;
  } stim_entry_t;

  typedef struct {
    logic [PixW-1:0] redness;
    int unsigned     pixel_no;
  } redness_exp_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata  = '0;  // blue, green, red
  logic [0:0]      s_axis_tuser  = '0;  // frame_start
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b1;
  logic [7:0]      m_axis_tdata;        // redness
  logic            cfg_we_i      = 1'b0;
  logic [LwW-1:0]  cfg_wdata_i   = '0;

  red_led_hue_redness_map_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predictor state, mirroring the unit.
  logic [LwW-1:0]   line_width_q    = LineWidthReset;
  bit   [WordW-1:0] row_words [MaxWidth];
  bit   [WordW-1:0] left_word       = '0;
  bit   [WordW-1:0] upper_left_word = '0;
  int unsigned      col_pos         = 0;
  bit               first_row       = 1'b1;

  stim_entry_t  pixel_words_q [$];
  redness_exp_t redness_exp_q [$];

  int unsigned gen_width      = 32'(LineWidthReset);
  bit          gen_need_start = 1'b0;
  int unsigned planned_pixels = 0;

  int unsigned cycle_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned words_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned results_acked = 0;
  int unsigned results_noted = 0;
  int unsigned fail_count    = 0;
  int unsigned gray_count    = 0;
  int unsigned start_count   = 0;
  int unsigned width_writes  = 0;

  int unsigned     tx_gap    = 0;
  int unsigned     settle    = 0;
  bit              tx_burst  = 1'b0;
  int unsigned     rx_wait   = 0;
  bit              rx_burst  = 1'b0;
  logic            nxt_valid;
  logic            nxt_we;
  stim_entry_t     head;
  redness_exp_t    exp_head;
  logic [PixW-1:0] pred_redness;

  function automatic int score_of(bit [WordW-1:0] w);
    return 2 * int'(w[WordW-1:PixW]) - int'(w[PixW-1:0]);
  endfunction

  task automatic predict_redness(input logic [PixW-1:0] b, g, r, input logic fs,
                                 output logic [PixW-1:0] res);
    int unsigned      wdt;
    int unsigned      col;
    int               bi, gi, ri, mx, mn, d, n, acc, cnt, val;
    bit   [WordW-1:0] upper;
    bit   [WordW-1:0] word;
    bi  = int'(b);
    gi  = int'(g);
    ri  = int'(r);
    wdt = 32'(line_width_q);
    if (wdt == 0) wdt = 1;
    if (wdt > MaxWidth) wdt = MaxWidth;
    if (fs) begin
      col_pos   = 0;
      first_row = 1'b1;
      start_count++;
    end else if (col_pos >= wdt) begin
      col_pos   = 0;
      first_row = 1'b0;
    end
    col   = col_pos;
    upper = row_words[col[ColW-1:0]];
    mx = (bi > gi) ? bi : gi;
    if (ri > mx) mx = ri;
    mn = (bi < gi) ? bi : gi;
    if (ri < mn) mn = ri;
    if (mx == mn) begin
      // Gray: average the scores recovered from whichever neighbours exist.
      gray_count++;
      acc = 0;
      cnt = 0;
      if (col != 0) begin
        acc += score_of(left_word);
        cnt++;
      end
      if (!first_row) begin
        acc += score_of(upper);
        cnt++;
      end
      if (col != 0 && !first_row) begin
        acc += score_of(upper_left_word);
        cnt++;
      end
      if (cnt == 0) begin
        val = (ri + int'(GrayNoNeighbour)) / 2;
      end else begin
        val = cnt * ri + acc;
        val = (val <= 0) ? 0 : val / (2 * cnt);
      end
    end else begin
      d = mx - mn;
      if (ri == mx) n = (gi >= bi) ? gi - bi : bi - gi;
      else if (gi == mx) n = 2 * d + bi - ri;
      else n = 2 * d + gi - ri;
      val = (ri + int'(PixMax) * (3 * d - n) / (3 * d)) / 2;
    end
    if (val > int'(PixMax)) val = int'(PixMax);
    res             = val[PixW-1:0];
    word            = {res, r};
    upper_left_word = upper;
    row_words[col[ColW-1:0]] = word;
    left_word       = word;
    col_pos         = col + 1;
    if (col_pos >= wdt) begin
      col_pos   = 0;
      first_row = 1'b0;
    end
  endtask

  task automatic plan_pixel(input logic [PixW-1:0] b, g, r, input logic fs);
    stim_entry_t e;
    e.kind         = ENT_PIXEL;
    e.blue         = b;
    e.green        = g;
    e.red          = r;
    // A wider row than the frame has seen must open a new frame.
    e.frame_start  = fs | gen_need_start;
    e.width        = '0;
    gen_need_start = 1'b0;
    pixel_words_q.push_back(e);
    planned_pixels++;
  endtask

  task automatic plan_width(input logic [LwW-1:0] w);
    stim_entry_t e;
    int unsigned eff;
    eff = (w == 0) ? 1 : ((w > MaxWidth) ? MaxWidth : w);
    if (eff > gen_width) gen_need_start = 1'b1;
    gen_width     = eff;
    e.kind        = ENT_WIDTH;
    e.blue        = '0;
    e.green       = '0;
    e.red         = '0;
    e.frame_start = 1'b0;
    e.width       = w;
    pixel_words_q.push_back(e);
  endtask

  task automatic plan_random_pixel(input bit fs);
    logic [PixW-1:0] b, g, r, x, y;
    x = PixW'($urandom_range(0, 255));
    y = PixW'($urandom_range(0, 255));
    b = PixW'($urandom_range(0, 255));
    g = PixW'($urandom_range(0, 255));
    r = PixW'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 3))
          0: x = $urandom_range(0, 1) ? PixMax : '0;
          1: x = PixW'($urandom_range(0, 3));
          default: ;
        endcase
        b = x;
        g = x;
        r = x;
      end
      3: begin
        b = $urandom_range(0, 1) ? PixMax : '0;
        g = $urandom_range(0, 1) ? PixMax : '0;
        r = $urandom_range(0, 1) ? PixMax : '0;
      end
      4: begin
        case ($urandom_range(0, 2))
          0: {b, g, r} = {x, x, y};
          1: {b, g, r} = {x, y, x};
          default: {b, g, r} = {y, x, x};
        endcase
      end
      5: begin
        // Near cyan: a score of zero, and a negative recovered score for odd red.
        b = x;
        g = x;
        r = PixW'($urandom_range(0, x));
      end
      default: ;
    endcase
    plan_pixel(b, g, r, fs);
  endtask

  task automatic plan_phase(input logic [LwW-1:0] w, input int unsigned len,
                            input bit keep_row);
    plan_width(w);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) plan_random_pixel(!keep_row && $urandom_range(0, 1));
      else plan_random_pixel($urandom_range(0, 59) == 0);
    end
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d of %0d redness words seen.",
             cycle_count, results_seen, planned_pixels);
    $display("** red_led_hue_redness_map_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [LwW-1:0] w;
    // The first pixel after reset opens a frame without the flag.
    plan_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    plan_pixel(8'd255, 8'd255, 8'd1, 1'b0);
    plan_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    plan_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    plan_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    plan_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    plan_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    plan_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    plan_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    plan_pixel(8'd128, 8'd64, 8'd200, 1'b0);
    plan_pixel(8'd3, 8'd1, 8'd2, 1'b0);
    plan_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    plan_width(12'd2);
    plan_pixel(8'd255, 8'd255, 8'd1, 1'b1);
    plan_pixel(8'd255, 8'd255, 8'd1, 1'b0);
    plan_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    plan_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    plan_pixel(8'd17, 8'd17, 8'd17, 1'b0);
    plan_pixel(8'd200, 8'd200, 8'd200, 1'b0);

    // Mid-row shrinks, the zero and saturating widths, then random phases.
    plan_phase(12'd6, 10, 1'b0);
    plan_phase(12'd3, 12, 1'b1);
    plan_phase(12'd0, 10, 1'b1);
    plan_phase('1, 40, 1'b0);
    plan_phase(MaxWidth[LwW-1:0], 35, 1'b1);
    plan_phase(12'd5, 30, 1'b1);
    while (planned_pixels < RandomPixels + 18) begin
      case ($urandom_range(0, 15))
        0: w = '0;
        1: w = 12'd1;
        2: w = MaxWidth[LwW-1:0];
        3: w = '1;
        4: w = LineWidthReset;
        5, 6, 7, 8, 9: w = LwW'($urandom_range(2, 8));
        default: w = LwW'($urandom_range(9, 64));
      endcase
      if (w > 64 || w == 0) plan_phase(w, $urandom_range(20, 40), 1'($urandom_range(0, 1)));
      else plan_phase(w, $urandom_range(20, 80), 1'($urandom_range(0, 1)));
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (results_seen >= planned_pixels);
    repeat (TailCycles) @(posedge clk_i);
    $display("Checked %0d redness words from %0d pixel words, %0d of them gray.",
             results_seen, words_taken, gray_count);
    $display("Covered %0d frame starts and %0d row width writes, with random stalls both ways.",
             start_count, width_writes);
    if (fail_count == 0 && redness_exp_q.size() == 0) begin
      $display("** red_led_hue_redness_map_unit: PASSED **");
    end else begin
      $display("** red_led_hue_redness_map_unit: FAILED **");
    end
    $finish;
  end

  // Sender: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    nxt_valid = s_axis_tvalid;
    nxt_we    = 1'b0;
    if (nxt_valid && words_taken == words_sent) nxt_valid = 1'b0;
    if (rst_ni && !nxt_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pixel_words_q.size() != 0) begin
        if (pixel_words_q[0].kind == ENT_WIDTH) begin
          // Width changes wait until every outstanding word has come back.
          if (results_seen == words_taken && words_taken == words_sent) settle++;
          else settle = 0;
          if (settle > WidthSettle) begin
            head = pixel_words_q.pop_front();
            nxt_we = 1'b1;
            cfg_wdata_i <= head.width;
            settle   = 0;
            tx_burst = ($urandom_range(0, 3) == 0);
            width_writes++;
          end
        end else begin
          head = pixel_words_q.pop_front();
          s_axis_tdata <= {head.red, head.green, head.blue};
          s_axis_tuser <= head.frame_start;
          nxt_valid = 1'b1;
          words_sent++;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    cfg_we_i      <= nxt_we;
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    if (results_acked != results_noted) begin
      results_noted = results_acked;
      if (results_noted % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
    end
    if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: everything sampled on the rising edge.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (cfg_we_i) line_width_q = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        results_acked++;
        if (redness_exp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("[%0t] redness word %0d with no pixel word outstanding", $time,
                     m_axis_tdata);
        end else begin
          exp_head = redness_exp_q.pop_front();
          results_seen++;
          if (m_axis_tdata !== exp_head.redness) begin
            fail_count++;
            if (fail_count <= ReportMax)
              $display("[%0t] pixel %0d: redness expected %0d, got %0d", $time,
                       exp_head.pixel_no, exp_head.redness, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_redness(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                        s_axis_tuser[0], pred_redness);
        redness_exp_q.push_back('{pred_redness, words_taken});
        words_taken++;
      end
    end
  end

endmodule
